>>> rtl/sha256_byte_stream_hasher_defines.svh
// Assertion helpers for the top-level hasher, the one file that checks its own logic.
// Each macro takes a label, a condition and the expected consequence.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// The consequence must hold in the same cycle as the condition.
`define SHABSH_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error("same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define SHABSH_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error("next-cycle check failed");

`endif

>>> rtl/shabsh_pkg.sv
package shabsh_pkg;

    typedef logic [0:7][31:0] t_hash;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    // Control from the sequencer to the compression datapath.
    typedef struct packed {
        logic       ins_valid;
        logic [7:0] ins_byte;
        logic       load;
        logic       round_en;
        logic [5:0] round_idx;
        logic       update;
        logic       reinit;
    } t_core_ctrl;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] CNT_LAST   = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    localparam t_hash INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

>>> rtl/shabsh_core.sv
module shabsh_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  shabsh_pkg::t_core_ctrl i_ctrl,
    output shabsh_pkg::t_hash      o_hash
);

    logic [31:0]       r_w [0:15];
    shabsh_pkg::t_hash r_v;
    shabsh_pkg::t_hash r_h;

    logic [31:0]       w_next;
    logic [31:0]       t1;
    logic [31:0]       t2;
    logic [31:0]       ch;
    logic [31:0]       maj;
    shabsh_pkg::t_hash n_v;

    always_comb begin
        w_next = shabsh_pkg::small_sigma1(r_w[14]) + r_w[9]
               + shabsh_pkg::small_sigma0(r_w[1]) + r_w[0];
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + shabsh_pkg::big_sigma1(r_v[4]) + ch
            + shabsh_pkg::ROUND_K[i_ctrl.round_idx] + r_w[0];
        t2  = shabsh_pkg::big_sigma0(r_v[0]) + maj;
        n_v = {t1 + t2, r_v[0], r_v[1], r_v[2], r_v[3] + t1, r_v[4], r_v[5], r_v[6]};
    end

    // The schedule window doubles as the block buffer: bytes shift in at the
    // bottom, and during the rounds whole words shift out at the top.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins_valid) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i + 1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], i_ctrl.ins_byte};
        end else if (i_ctrl.round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_v <= r_h;
        end else if (i_ctrl.round_en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.reinit) begin
            r_h <= shabsh_pkg::INIT_H;
        end else if (i_ctrl.update) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    assign o_hash = r_h;

endmodule

>>> rtl/sha256_byte_stream_hasher.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready tdata: byte; tuser: finish
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready tdata: word, index; tlast
//
// A data byte is taken only while idle; every 64th byte adds 64 rounds and one
// chaining update in the single round unit. A finish is taken on its own, then one
// padding byte, zero bytes up to the length position, one spare step before the length
// bytes, one or two compressions, then eight digest words, one per output request.
// Reset is synchronous and active low; it loads the initial hash values.
// A stalled output holds the current word; no input is taken until all eight leave.
`include "sha256_byte_stream_hasher_defines.svh"

module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  i_s_axis_tuser,   // [0] command (1 = finish)
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest 0
    output logic        o_m_axis_tlast    // last_word
);

    shabsh_pkg::t_state     r_state;
    shabsh_pkg::t_state     n_state;
    shabsh_pkg::t_core_ctrl ctrl;
    shabsh_pkg::t_hash      hash;

    logic [5:0]  r_cnt;
    logic [63:0] r_bit_cnt;
    logic [63:0] r_len;
    logic [5:0]  r_round;
    logic [2:0]  r_widx;
    logic        r_fin;
    logic        r_len_blk;

    logic in_acc;
    logic out_acc;
    logic cnt_full;

    assign o_s_axis_tready = (r_state == shabsh_pkg::ST_IDLE);
    assign o_m_axis_tvalid = (r_state == shabsh_pkg::ST_EMIT);

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc  = o_m_axis_tvalid && i_m_axis_tready;
    assign cnt_full = (r_cnt == shabsh_pkg::CNT_LAST);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            shabsh_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_s_axis_tuser[0]) begin
                        n_state = shabsh_pkg::ST_PAD80;
                    end else if (cnt_full) begin
                        n_state = shabsh_pkg::ST_ROUND;
                    end
                end
            end
            shabsh_pkg::ST_PAD80: begin
                n_state = cnt_full ? shabsh_pkg::ST_ROUND : shabsh_pkg::ST_PADZ;
            end
            shabsh_pkg::ST_PADZ: begin
                if (r_cnt == shabsh_pkg::LEN_POS) begin
                    n_state = shabsh_pkg::ST_PADLEN;
                end else if (cnt_full) begin
                    n_state = shabsh_pkg::ST_ROUND;
                end
            end
            shabsh_pkg::ST_PADLEN: begin
                if (cnt_full) begin
                    n_state = shabsh_pkg::ST_ROUND;
                end
            end
            shabsh_pkg::ST_ROUND: begin
                if (r_round == shabsh_pkg::ROUND_LAST) begin
                    n_state = shabsh_pkg::ST_UPDATE;
                end
            end
            shabsh_pkg::ST_UPDATE: begin
                if (r_len_blk) begin
                    n_state = shabsh_pkg::ST_EMIT;
                end else if (r_fin) begin
                    n_state = shabsh_pkg::ST_PADZ;
                end else begin
                    n_state = shabsh_pkg::ST_IDLE;
                end
            end
            shabsh_pkg::ST_EMIT: begin
                if (out_acc && r_widx == shabsh_pkg::WORD_LAST) begin
                    n_state = shabsh_pkg::ST_IDLE;
                end
            end
            default: n_state = shabsh_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl            = '0;
        ctrl.round_idx  = r_round;
        unique case (r_state)
            shabsh_pkg::ST_IDLE: begin
                if (in_acc && !i_s_axis_tuser[0]) begin
                    ctrl.ins_valid = 1'b1;
                    ctrl.ins_byte  = i_s_axis_tdata;
                    ctrl.load      = cnt_full;
                end
            end
            shabsh_pkg::ST_PAD80: begin
                ctrl.ins_valid = 1'b1;
                ctrl.ins_byte  = shabsh_pkg::PAD_BYTE;
                ctrl.load      = cnt_full;
            end
            shabsh_pkg::ST_PADZ: begin
                if (r_cnt != shabsh_pkg::LEN_POS) begin
                    ctrl.ins_valid = 1'b1;
                    ctrl.load      = cnt_full;
                end
            end
            shabsh_pkg::ST_PADLEN: begin
                ctrl.ins_valid = 1'b1;
                ctrl.ins_byte  = r_len[63:56];
                ctrl.load      = cnt_full;
            end
            shabsh_pkg::ST_ROUND: begin
                ctrl.round_en = 1'b1;
            end
            shabsh_pkg::ST_UPDATE: begin
                ctrl.update = 1'b1;
            end
            shabsh_pkg::ST_EMIT: begin
                ctrl.reinit     = out_acc && (r_widx == shabsh_pkg::WORD_LAST);
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= shabsh_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_bit_cnt <= '0;
            r_round   <= '0;
            r_widx    <= '0;
            r_fin     <= 1'b0;
            r_len_blk <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctrl.reinit) begin
                r_cnt <= '0;
            end else if (ctrl.ins_valid) begin
                r_cnt <= r_cnt + 6'd1;
            end
            if (ctrl.reinit) begin
                r_bit_cnt <= '0;
            end else if (ctrl.ins_valid && r_state == shabsh_pkg::ST_IDLE) begin
                r_bit_cnt <= r_bit_cnt + 64'd8;
            end
            r_round <= ctrl.round_en ? r_round + 6'd1 : '0;
            if (out_acc) begin
                r_widx <= r_widx + 3'd1;
            end
            if (ctrl.reinit) begin
                r_fin <= 1'b0;
            end else if (in_acc && i_s_axis_tuser[0]) begin
                r_fin <= 1'b1;
            end
            if (ctrl.reinit) begin
                r_len_blk <= 1'b0;
            end else if (n_state == shabsh_pkg::ST_PADLEN) begin
                r_len_blk <= 1'b1;
            end
        end
    end

    // Message length in bits, sent most significant byte first.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_s_axis_tuser[0]) begin
            r_len <= r_bit_cnt;
        end else if (r_state == shabsh_pkg::ST_PADLEN) begin
            r_len <= {r_len[55:0], 8'h00};
        end
    end

    shabsh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_hash  (hash)
    );

    assign o_m_axis_tdata = {5'b00000, r_widx, hash[r_widx]};
    assign o_m_axis_tlast = (r_widx == shabsh_pkg::WORD_LAST);

    `SHABSH_ASSERT_SAME(a_no_overlap, o_m_axis_tvalid, !o_s_axis_tready)
    `SHABSH_ASSERT_NEXT(a_finish_starts_pad, in_acc && i_s_axis_tuser[0],
        r_state == shabsh_pkg::ST_PAD80)
    `SHABSH_ASSERT_NEXT(a_last_word_clears, out_acc && o_m_axis_tlast,
        r_state == shabsh_pkg::ST_IDLE && r_cnt == 6'd0 && r_bit_cnt == 64'd0)
    `SHABSH_ASSERT_NEXT(a_rounds_end,
        r_state == shabsh_pkg::ST_ROUND && r_round == shabsh_pkg::ROUND_LAST,
        r_state == shabsh_pkg::ST_UPDATE)

endmodule
